// ===== sv/http_chunked_body_decoder_top_defines.svh =====
// Assertion helpers used by the decoder back end.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HCBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// Next-cycle implication, disabled while in reset.
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

// ===== sv/hcbd_pkg.sv =====
`default_nettype none
package hcbd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_LF = 3'd1,
        PH_EXT     = 3'd2,
        PH_DATA    = 3'd3,
        PH_SKIP    = 3'd4,
        PH_TRAILER = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_MORE     = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_BADSIZE  = 3'd2,
        ST_TOOLARGE = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    localparam logic [1:0] SKIP_AFTER_DATA = 2'd2;
    localparam logic [1:0] TM_NONE   = 2'd0;
    localparam logic [1:0] TM_CR     = 2'd1;
    localparam logic [1:0] TM_CRLF   = 2'd2;
    localparam logic [1:0] TM_CRLFCR = 2'd3;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic [7:0] data;
        logic       new_msg;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_semi;
        logic       is_cr;
        logic       is_lf;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

endpackage
`default_nettype wire

// ===== sv/hcbd_front.sv =====
`default_nettype none
module hcbd_front (
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     data_byte,
    input  wire logic           new_message,
    input  wire logic           q_full,
    output hcbd_pkg::push_t     push
);

    logic       is_hex;
    logic [3:0] hex_val;

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        case (data_byte) inside
            [8'h30:8'h39]:
            begin
                hex_val = data_byte[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]:
            begin
                hex_val = data_byte[3:0] + 4'd9;
            end
            default:
            begin
                is_hex = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;

    always_comb
    begin
        push.push         = in_valid && !q_full;
        push.item.data    = data_byte;
        push.item.new_msg = new_message;
        push.item.is_hex  = is_hex;
        push.item.hex_val = hex_val;
        push.item.is_semi = (data_byte == hcbd_pkg::CH_SEMI);
        push.item.is_cr   = (data_byte == hcbd_pkg::CH_CR);
        push.item.is_lf   = (data_byte == hcbd_pkg::CH_LF);
    end

endmodule
`default_nettype wire

// ===== sv/hcbd_queue.sv =====
`default_nettype none
module hcbd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hcbd_pkg::push_t    push,
    output logic                    full,
    output logic                    not_empty,
    input  wire logic               pop,
    output hcbd_pkg::item_t         head
);

    hcbd_pkg::item_t                     mem [hcbd_pkg::QUEUE_DEPTH];
    logic [hcbd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [hcbd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [hcbd_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;
    logic                                do_push;
    logic                                do_pop;

    assign full      = (count_reg == hcbd_pkg::QUEUE_CNT_W'(hcbd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push.push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hcbd_back.sv =====
`default_nettype none
`include "http_chunked_body_decoder_top_defines.svh"
module hcbd_back #(
    parameter int LEN_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [31:0]        body_cap,
    input  wire logic               q_not_empty,
    input  wire hcbd_pkg::item_t    item,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              body_byte,
    output logic                    body_valid,
    output logic [2:0]              status
);

    localparam int CW = (LEN_BITS > 32) ? LEN_BITS : 32;

    hcbd_pkg::phase_t       phase_reg, phase_next, cur_phase;
    logic [LEN_BITS-1:0]    cnt_reg, cnt_next, cur_cnt;
    logic                   seen_reg, seen_next, cur_seen;
    logic [LEN_BITS-1:0]    total_reg, total_next, cur_total;
    logic [1:0]             skip_reg, skip_next, cur_skip;
    logic [1:0]             tm_reg, tm_next, cur_tm;
    logic                   ek_reg, ek_next, cur_ek;

    logic                   out_valid_reg;
    logic [7:0]             body_byte_reg;
    logic                   body_valid_reg;
    hcbd_pkg::status_t      status_reg;

    logic [7:0]             res_byte;
    logic                   res_valid;
    hcbd_pkg::status_t      res_status;

    logic [LEN_BITS:0]      sum_raw;
    logic [LEN_BITS-1:0]    sum_sat;
    logic [LEN_BITS-1:0]    cnt_shift;
    logic [LEN_BITS-1:0]    cnt_dec;
    logic                   esl_bad;
    logic                   esl_zero;
    logic                   esl_big;
    hcbd_pkg::status_t      esl_status;
    logic                   back_ready;

    assign back_ready = !out_valid_reg || !out_stall;
    assign pop        = q_not_empty && back_ready;

    // A new message starts from cleared state before its first byte.
    always_comb
    begin
        if (item.new_msg)
        begin
            cur_phase = hcbd_pkg::PH_SIZE;
            cur_cnt   = '0;
            cur_seen  = 1'b0;
            cur_total = '0;
            cur_skip  = '0;
            cur_tm    = '0;
            cur_ek    = 1'b0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_cnt   = cnt_reg;
            cur_seen  = seen_reg;
            cur_total = total_reg;
            cur_skip  = skip_reg;
            cur_tm    = tm_reg;
            cur_ek    = ek_reg;
        end
    end

    // End of size line: saturating running total and limit check.
    always_comb
    begin
        sum_raw    = {1'b0, cur_total} + {1'b0, cur_cnt};
        sum_sat    = sum_raw[LEN_BITS] ? '1 : sum_raw[LEN_BITS-1:0];
        esl_bad    = !cur_seen;
        esl_zero   = (cur_cnt == '0);
        esl_big    = (body_cap != '0) && (CW'(sum_sat) > CW'(body_cap));
        if (esl_bad)
        begin
            esl_status = hcbd_pkg::ST_BADSIZE;
        end
        else if (!esl_zero && esl_big)
        begin
            esl_status = hcbd_pkg::ST_TOOLARGE;
        end
        else
        begin
            esl_status = hcbd_pkg::ST_MORE;
        end
    end

    always_comb
    begin
        if (cur_cnt[LEN_BITS-1 -: 4] != 4'd0)
        begin
            cnt_shift = '1;
        end
        else
        begin
            cnt_shift = {cur_cnt[LEN_BITS-5:0], item.hex_val};
        end
        cnt_dec = cur_cnt - 1'b1;
    end

    // Next state.
    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt;
        seen_next  = cur_seen;
        total_next = cur_total;
        skip_next  = cur_skip;
        tm_next    = cur_tm;
        ek_next    = cur_ek;
        case (cur_phase)
            hcbd_pkg::PH_SIZE:
            begin
                if (item.is_hex)
                begin
                    cnt_next  = cnt_shift;
                    seen_next = 1'b1;
                end
                else if (item.is_semi)
                begin
                    phase_next = hcbd_pkg::PH_EXT;
                    skip_next  = '0;
                end
                else if (item.is_cr)
                begin
                    phase_next = hcbd_pkg::PH_SIZE_LF;
                end
                else
                begin
                    phase_next = hcbd_pkg::PH_ERROR;
                    ek_next    = 1'b0;
                end
            end
            hcbd_pkg::PH_SIZE_LF, hcbd_pkg::PH_EXT:
            begin
                if (cur_phase == hcbd_pkg::PH_EXT && !(cur_skip == 2'd1 && item.is_lf))
                begin
                    skip_next = {1'b0, item.is_cr};
                end
                else if (!item.is_lf || esl_bad)
                begin
                    skip_next  = '0;
                    phase_next = hcbd_pkg::PH_ERROR;
                    ek_next    = 1'b0;
                end
                else if (esl_zero)
                begin
                    skip_next  = '0;
                    phase_next = hcbd_pkg::PH_TRAILER;
                    tm_next    = hcbd_pkg::TM_CRLF;
                end
                else if (esl_big)
                begin
                    skip_next  = '0;
                    phase_next = hcbd_pkg::PH_ERROR;
                    ek_next    = 1'b1;
                end
                else
                begin
                    skip_next  = '0;
                    total_next = sum_sat;
                    phase_next = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    phase_next = hcbd_pkg::PH_SKIP;
                    skip_next  = hcbd_pkg::SKIP_AFTER_DATA;
                end
            end
            hcbd_pkg::PH_SKIP:
            begin
                skip_next = cur_skip - 1'b1;
                if (cur_skip == 2'd1)
                begin
                    phase_next = hcbd_pkg::PH_SIZE;
                    cnt_next   = '0;
                    seen_next  = 1'b0;
                end
            end
            hcbd_pkg::PH_TRAILER:
            begin
                if (cur_tm == hcbd_pkg::TM_CRLFCR && item.is_lf)
                begin
                    tm_next    = hcbd_pkg::TM_NONE;
                    phase_next = hcbd_pkg::PH_DONE;
                end
                else if ((cur_tm == hcbd_pkg::TM_NONE || cur_tm == hcbd_pkg::TM_CRLF)
                         && item.is_cr)
                begin
                    tm_next = cur_tm + 1'b1;
                end
                else if (cur_tm == hcbd_pkg::TM_CR && item.is_lf)
                begin
                    tm_next = hcbd_pkg::TM_CRLF;
                end
                else if (item.is_cr)
                begin
                    tm_next = hcbd_pkg::TM_CR;
                end
                else
                begin
                    tm_next = hcbd_pkg::TM_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result for this request.
    always_comb
    begin
        res_byte   = 8'd0;
        res_valid  = 1'b0;
        res_status = hcbd_pkg::ST_MORE;
        case (cur_phase)
            hcbd_pkg::PH_SIZE:
            begin
                if (!item.is_hex && !item.is_semi && !item.is_cr)
                begin
                    res_status = hcbd_pkg::ST_BADSIZE;
                end
            end
            hcbd_pkg::PH_SIZE_LF:
            begin
                res_status = item.is_lf ? esl_status : hcbd_pkg::ST_BADSIZE;
            end
            hcbd_pkg::PH_EXT:
            begin
                if (cur_skip == 2'd1 && item.is_lf)
                begin
                    res_status = esl_status;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                res_byte  = item.data;
                res_valid = 1'b1;
            end
            hcbd_pkg::PH_TRAILER:
            begin
                if (cur_tm == hcbd_pkg::TM_CRLFCR && item.is_lf)
                begin
                    res_status = hcbd_pkg::ST_COMPLETE;
                end
            end
            hcbd_pkg::PH_DONE:
            begin
                res_status = hcbd_pkg::ST_IGNORED;
            end
            hcbd_pkg::PH_ERROR:
            begin
                res_status = cur_ek ? hcbd_pkg::ST_TOOLARGE : hcbd_pkg::ST_BADSIZE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hcbd_pkg::PH_SIZE;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            total_reg     <= '0;
            skip_reg      <= '0;
            tm_reg        <= '0;
            ek_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                seen_reg      <= seen_next;
                total_reg     <= total_next;
                skip_reg      <= skip_next;
                tm_reg        <= tm_next;
                ek_reg        <= ek_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            body_byte_reg  <= res_byte;
            body_valid_reg <= res_valid;
            status_reg     <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign body_byte  = body_byte_reg;
    assign body_valid = body_valid_reg;
    assign status     = status_reg;

    `HCBD_ASSERT_NOW(a_data_status_more, clk, rst_n,
        out_valid_reg && body_valid_reg, status_reg == hcbd_pkg::ST_MORE)
    `HCBD_ASSERT_NOW(a_data_count_nonzero, clk, rst_n,
        phase_reg == hcbd_pkg::PH_DATA, cnt_reg != '0)
    `HCBD_ASSERT_NEXT(a_done_sticks, clk, rst_n,
        phase_reg == hcbd_pkg::PH_DONE && !(pop && item.new_msg),
        phase_reg == hcbd_pkg::PH_DONE)

endmodule
`default_nettype wire

// ===== sv/http_chunked_body_decoder_top.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------
// input    | in_valid / in_stall  | data_byte[7:0], new_message
// output   | out_valid / out_stall| body_byte[7:0], body_valid, status[2:0]
// config   | cfg_we               | cfg_data[31:0] (body size cap)
//
// One byte per clock while not stalled; bytes pass the queue, then the output register.
// The front classifies the byte into a 2-entry queue; the back runs the
// parser state and owns the output register, one request per cycle when not stalled.
// Reset (rst_n low) clears the parser, the queue and the body size cap.
// in_stall rises only while the queue is full, i.e. after out_stall backs up.
`default_nettype none
module http_chunked_body_decoder_top #(
    parameter int LEN_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_data,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     data_byte,
    input  wire logic           new_message,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          body_byte,
    output logic                body_valid,
    output logic [2:0]          status
);

    logic [31:0]        body_cap_reg;
    hcbd_pkg::push_t    push;
    hcbd_pkg::item_t    head;
    logic               q_full;
    logic               q_not_empty;
    logic               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_cap_reg <= '0;
        end
        else if (cfg_we)
        begin
            body_cap_reg <= cfg_data;
        end
    end

    hcbd_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .new_message (new_message),
        .q_full      (q_full),
        .push        (push)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head      (head)
    );

    hcbd_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .body_cap      (body_cap_reg),
        .q_not_empty   (q_not_empty),
        .item          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .body_byte     (body_byte),
        .body_valid    (body_valid),
        .status        (status)
    );

endmodule
`default_nettype wire

// ===== tb/chunked_body_checker.sv =====
module chunked_body_checker
    import hcbd_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        new_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  body_byte,
    input  logic        body_valid,
    input  logic [2:0]  status,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        status_t    st;
    } body_result_t;

    localparam logic [LEN_BITS-1:0] LEN_ALL = '1;

    // Decoder image: limit register plus parser state.
    logic [31:0]         body_limit;
    phase_t              ph;
    logic [LEN_BITS-1:0] size_left;
    logic                digit_seen;
    logic [LEN_BITS-1:0] body_total;
    logic [1:0]          skip_left;
    logic [1:0]          crlf_prog;
    logic                err_large;

    body_result_t        expected_bodies[$];
    body_result_t        want;

    initial fail_count = 0;

    function automatic void clear_decoder();
        ph         = PH_SIZE;
        size_left  = '0;
        digit_seen = 1'b0;
        body_total = '0;
        skip_left  = '0;
        crlf_prog  = TM_NONE;
        err_large  = 1'b0;
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= "0" && c <= "9")
        begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f")
        begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F")
        begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic status_t raise_err(input logic too_big);
        ph        = PH_ERROR;
        err_large = too_big;
        if (too_big)
            return ST_TOOLARGE;
        return ST_BADSIZE;
    endfunction

    // Size line complete: no digit is an error, zero size goes to the trailer, else check the limit.
    function automatic status_t close_size_line();
        logic [LEN_BITS:0] sum;
        if (!digit_seen)
            return raise_err(1'b0);
        if (size_left == '0)
        begin
            ph        = PH_TRAILER;
            crlf_prog = TM_CRLF;
            return ST_MORE;
        end
        sum = {1'b0, body_total} + {1'b0, size_left};
        if (sum[LEN_BITS])
            sum[LEN_BITS-1:0] = LEN_ALL;
        if (body_limit != 0 && sum[LEN_BITS-1:0] > body_limit)
            return raise_err(1'b1);
        body_total = sum[LEN_BITS-1:0];
        ph         = PH_DATA;
        return ST_MORE;
    endfunction

    function automatic body_result_t decode_byte(input logic [7:0] c, input logic nm);
        body_result_t r;
        logic [3:0]   nib;
        r.data  = 8'h00;
        r.valid = 1'b0;
        r.st    = ST_MORE;
        if (nm)
            clear_decoder();
        case (ph)
            PH_SIZE:
            begin
                if (hex_nibble(c, nib))
                begin
                    if (size_left > (LEN_ALL >> 4))
                        size_left = LEN_ALL;
                    else
                        size_left = {size_left[LEN_BITS-5:0], nib};
                    digit_seen = 1'b1;
                end
                else if (c == CH_SEMI)
                begin
                    ph        = PH_EXT;
                    skip_left = '0;
                end
                else if (c == CH_CR)
                    ph = PH_SIZE_LF;
                else
                    r.st = raise_err(1'b0);
            end
            PH_SIZE_LF:
            begin
                if (c == CH_LF)
                    r.st = close_size_line();
                else
                    r.st = raise_err(1'b0);
            end
            PH_EXT:
            begin
                // skip_left doubles as a CR-seen flag inside an extension
                if (skip_left == 2'd1 && c == CH_LF)
                begin
                    skip_left = '0;
                    r.st      = close_size_line();
                end
                else
                    skip_left = (c == CH_CR) ? 2'd1 : 2'd0;
            end
            PH_DATA:
            begin
                r.valid   = 1'b1;
                r.data    = c;
                size_left = size_left - 1'b1;
                if (size_left == '0)
                begin
                    ph        = PH_SKIP;
                    skip_left = SKIP_AFTER_DATA;
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 2'd1;
                if (skip_left == '0)
                begin
                    ph         = PH_SIZE;
                    size_left  = '0;
                    digit_seen = 1'b0;
                end
            end
            PH_TRAILER:
            begin
                if (crlf_prog == TM_CRLFCR && c == CH_LF)
                begin
                    crlf_prog = TM_NONE;
                    ph        = PH_DONE;
                    r.st      = ST_COMPLETE;
                end
                else if ((crlf_prog == TM_NONE || crlf_prog == TM_CRLF) && c == CH_CR)
                    crlf_prog = crlf_prog + 2'd1;
                else if (crlf_prog == TM_CR && c == CH_LF)
                    crlf_prog = TM_CRLF;
                else if (c == CH_CR)
                    crlf_prog = TM_CR;
                else
                    crlf_prog = TM_NONE;
            end
            PH_DONE:
                r.st = ST_IGNORED;
            default:
            begin
                if (err_large)
                    r.st = ST_TOOLARGE;
                else
                    r.st = ST_BADSIZE;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decoder();
            body_limit = '0;
            expected_bodies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                body_limit = cfg_data;
            if (in_valid && !in_stall)
                expected_bodies.push_back(decode_byte(data_byte, new_message));
            if (out_valid && !out_stall)
            begin
                if (expected_bodies.size() == 0)
                begin
                    $error("result with no request pending: body_byte %0h status %0d",
                           body_byte, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_bodies.pop_front();
                    if (body_byte !== want.data)
                    begin
                        $error("body_byte mismatch: expected %0h actual %0h",
                               want.data, body_byte);
                        fail_count++;
                    end
                    if (body_valid !== want.valid)
                    begin
                        $error("body_valid mismatch: expected %0d actual %0d",
                               want.valid, body_valid);
                        fail_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status mismatch: expected %0d actual %0d",
                               want.st, status);
                        fail_count++;
                    end
                end
            end
            outstanding <= expected_bodies.size();
        end
    end

endmodule

// ===== tb/tb_http_chunked_body_decoder_top.sv =====
module tb_http_chunked_body_decoder_top;
    import hcbd_pkg::*;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [31:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte   = '0;
    logic        new_message = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  body_byte;
    logic        body_valid;
    logic [2:0]  status;

    int          fail_count;
    int          outstanding;
    int          sent_count  = 0;
    int          hold_req    = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    logic [7:0]  req_bytes[$];

    http_chunked_body_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .new_message (new_message),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .body_byte   (body_byte),
        .body_valid  (body_valid),
        .status      (status)
    );

    chunked_body_checker u_body_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .new_message (new_message),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .body_byte   (body_byte),
        .body_valid  (body_valid),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("tb_http_chunked_body_decoder_top failed");
        $finish;
    end

    // Output side: long hold-off on request, otherwise short random stalls.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_req(input logic [7:0] c, input logic nm);
        if (tx_idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= c;
        new_message <= nm;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_seq(input bit start_new, input int nm_at);
        foreach (req_bytes[i])
            send_req(req_bytes[i], (i == 0 && start_new) || i == nm_at);
    endtask

    // Stop offering and wait for every outstanding result plus pipeline slack.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endtask

    task automatic put_crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endtask

    // Hex size with random letter case and occasional leading zeros.
    task automatic put_size(input logic [31:0] v);
        string s;
        s = $sformatf("%0h", v);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) req_bytes.push_back("0");
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] >= "a" && $urandom_range(0, 1))
                req_bytes.push_back(s[i] - 8'd32);
            else
                req_bytes.push_back(s[i]);
        end
    endtask

    task automatic put_ext();
        req_bytes.push_back(CH_SEMI);
        repeat ($urandom_range(0, 6)) req_bytes.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) == 0)
        begin
            req_bytes.push_back(CH_CR);
            req_bytes.push_back("x");
        end
    endtask

    task automatic put_trailer_line();
        repeat ($urandom_range(1, 8)) req_bytes.push_back(8'($urandom_range(97, 122)));
        req_bytes.push_back(":");
        if ($urandom_range(0, 4) == 0)
        begin
            req_bytes.push_back(CH_CR);
            req_bytes.push_back("q");
        end
        put_crlf();
    endtask

    task automatic build_message();
        int len;
        req_bytes.delete();
        repeat ($urandom_range(0, 4))
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            put_size(len);
            if ($urandom_range(0, 3) == 0)
                put_ext();
            put_crlf();
            repeat (len) req_bytes.push_back(8'($urandom_range(0, 255)));
            // the two bytes after the data are not checked by the block
            if ($urandom_range(0, 7) == 0)
                repeat (2) req_bytes.push_back(8'($urandom_range(0, 255)));
            else
                put_crlf();
        end
        put_size(0);
        if ($urandom_range(0, 3) == 0)
            put_ext();
        put_crlf();
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) put_trailer_line();
        put_crlf();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_noise();
        int pos;
        case ($urandom_range(0, 5))
            0:
            begin
                build_message();
                pos = $urandom_range(0, req_bytes.size() - 1);
                req_bytes[pos] = 8'($urandom_range(0, 255));
            end
            1:
            begin
                build_message();
                pos = $urandom_range(1, req_bytes.size());
                req_bytes = req_bytes[0:pos-1];
            end
            2:
            begin
                req_bytes.delete();
                repeat ($urandom_range(1, 10)) req_bytes.push_back(8'($urandom_range(0, 255)));
            end
            3:
            begin
                req_bytes.delete();
                if ($urandom_range(0, 1))
                    put_ext();
                put_crlf();
            end
            4:
            begin
                // size wider than the counter: saturates
                req_bytes.delete();
                put_str($sformatf("1%08h", $urandom));
                repeat ($urandom_range(0, 2)) req_bytes.push_back("f");
                put_crlf();
                repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                req_bytes.delete();
                put_str("A");
                req_bytes.push_back(CH_CR);
                req_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial
    begin
        logic [31:0] limits[6];
        int          phase_start;

        limits = '{32'hFFFF_FFFF, 32'd24, 32'd0, 32'd1, $urandom, 32'd120};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // one-byte chunk with extension, last chunk, then a byte after the end
        req_bytes.delete();
        put_str("1;x");
        put_crlf();
        req_bytes.push_back(8'hFF);
        put_str("zz0");
        put_crlf();
        put_crlf();
        send_seq(1'b1, -1);
        send_req("g", 1'b0);
        // non-hex size, then the error holds
        send_req("g", 1'b1);
        send_req(CH_CR, 1'b0);
        // CR without LF
        send_req(CH_CR, 1'b1);
        send_req("x", 1'b0);
        // empty size line
        send_req(CH_CR, 1'b1);
        send_req(CH_LF, 1'b0);
        // oversized size with no limit
        req_bytes.delete();
        put_str("1FFFFFFFF");
        put_crlf();
        req_bytes.push_back(8'h00);
        send_seq(1'b1, -1);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_limit(limits[p]);
            if (p == 2)
                hold_req = 300;
            phase_start = sent_count;
            while (sent_count - phase_start < 300)
            begin
                tx_idle_on = (p < 5) && ($urandom_range(0, 3) != 0);
                rx_idle_on = (p < 5) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 6) == 0)
                    build_noise();
                else
                    build_message();
                send_seq($urandom_range(0, 9) != 0,
                         ($urandom_range(0, 15) == 0) ? $urandom_range(1, req_bytes.size()) : -1);
            end
        end

        settle();
        if (fail_count == 0)
            $display("tb_http_chunked_body_decoder_top passed");
        else
            $display("tb_http_chunked_body_decoder_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hcbd_pkg.sv
sv/hcbd_front.sv
sv/hcbd_queue.sv
sv/hcbd_back.sv
sv/http_chunked_body_decoder_top.sv
tb/chunked_body_checker.sv
tb/tb_http_chunked_body_decoder_top.sv
